/* hw/rtl/hlfr_pkg.sv */
`default_nettype none

package hlfr_pkg;

    localparam int MAX_FRAME  = 256;
    localparam int OFS_W      = $clog2(MAX_FRAME);
    localparam int MEM_DEPTH  = 2 * MAX_FRAME;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);
    localparam int CFG_IDX_W  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_HEADER  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_HEADER = CFG_IDX_W'(1);

    localparam logic [7:0] FIRST_HEADER_RST  = 8'd170;
    localparam logic [7:0] SECOND_HEADER_RST = 8'd85;

    // header bytes plus length byte
    localparam logic [9:0] FRAME_OVERHEAD = 10'd3;

    typedef enum logic [1:0] {
        MODE_RX_BYTE     = 2'd0,
        MODE_LINE_ERR    = 2'd1,
        MODE_READ        = 2'd2,
        MODE_CLEAR_READY = 2'd3
    } mode_t;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_NOISE   = 3'd1;
    localparam logic [2:0] ERR_PARITY  = 3'd2;
    localparam logic [2:0] ERR_OVERRUN = 3'd3;
    localparam logic [2:0] ERR_FRAMING = 3'd4;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } mem_req_t;

    typedef struct packed {
        logic       frame_ready;
        logic [8:0] frame_length;
        logic [2:0] error_code;
        logic       overflow;
        logic       rd_hit;
    } status_t;

endpackage

`default_nettype wire

/* hw/rtl/hlfr_ram.sv */
`default_nettype none

module hlfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/hlfr_parser.sv */
`default_nettype none

module hlfr_parser (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              accept,
    input  wire logic [1:0]                        mode,
    input  wire logic [7:0]                        rx_byte,
    input  wire logic                              noise_err,
    input  wire logic                              parity_err,
    input  wire logic                              overrun_err,
    input  wire logic                              framing_err,
    input  wire logic [7:0]                        read_index,
    input  wire logic                              cfg_we,
    input  wire logic [hlfr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [7:0]                        cfg_data,
    output      hlfr_pkg::mem_req_t                mem_req,
    output      hlfr_pkg::status_t                 status_next
);

    import hlfr_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_LEN,
        PH_DATA
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [8:0] count_reg, count_next;
    logic [7:0] decl_reg, decl_next;
    logic       bank_reg, bank_next;
    logic       ready_reg, ready_next;
    logic [8:0] length_reg, length_next;
    logic [2:0] error_reg, error_next;
    logic       overflow_reg, overflow_next;
    logic [7:0] first_hdr_reg;
    logic [7:0] second_hdr_reg;

    logic [8:0] count_inc;
    logic       store_ok;
    logic       rd_hit;

    assign count_inc = count_reg + 9'd1;
    assign store_ok  = 32'(count_reg) < MAX_FRAME;

    always_comb begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        decl_next     = decl_reg;
        bank_next     = bank_reg;
        ready_next    = ready_reg;
        length_next   = length_reg;
        error_next    = error_reg;
        overflow_next = overflow_reg;
        rd_hit        = 1'b0;
        mem_req.en    = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.addr  = {bank_reg, OFS_W'(count_reg)};
        mem_req.wdata = rx_byte;

        if (accept) begin
            unique case (mode)
                MODE_RX_BYTE: begin
                    unique case (phase_reg)
                        PH_HUNT1: begin
                            if (rx_byte == first_hdr_reg) begin
                                mem_req.en   = 1'b1;
                                mem_req.we   = 1'b1;
                                mem_req.addr = {bank_reg, OFS_W'(0)};
                                count_next   = 9'd1;
                                phase_next   = PH_HUNT2;
                            end
                        end
                        PH_HUNT2: begin
                            if (rx_byte == second_hdr_reg) begin
                                mem_req.en = store_ok;
                                mem_req.we = store_ok;
                                count_next = count_inc;
                                phase_next = PH_LEN;
                            end else begin
                                count_next = 9'd0;
                                phase_next = PH_HUNT1;
                            end
                        end
                        PH_LEN: begin
                            mem_req.en = store_ok;
                            mem_req.we = store_ok;
                            decl_next  = rx_byte;
                            count_next = count_inc;
                            phase_next = PH_DATA;
                        end
                        PH_DATA: begin
                            mem_req.en = store_ok;
                            mem_req.we = store_ok;
                            count_next = count_inc;
                            if ({1'b0, count_inc} >= {2'b00, decl_reg} + FRAME_OVERHEAD) begin
                                if (32'(count_inc) > MAX_FRAME) begin
                                    overflow_next = 1'b1;
                                end else begin
                                    length_next = count_inc;
                                    bank_next   = ~bank_reg;
                                    ready_next  = 1'b1;
                                end
                                count_next = 9'd0;
                                decl_next  = 8'd0;
                                phase_next = PH_HUNT1;
                            end
                        end
                    endcase
                end
                MODE_LINE_ERR: begin
                    if (noise_err) begin
                        error_next = ERR_NOISE;
                    end else if (parity_err) begin
                        error_next = ERR_PARITY;
                    end else if (overrun_err) begin
                        error_next = ERR_OVERRUN;
                    end else if (framing_err) begin
                        error_next = ERR_FRAMING;
                    end
                end
                MODE_READ: begin
                    if ({1'b0, read_index} < length_reg && 32'(read_index) < MAX_FRAME) begin
                        rd_hit       = 1'b1;
                        mem_req.en   = 1'b1;
                        mem_req.addr = {~bank_reg, OFS_W'(read_index)};
                    end
                end
                MODE_CLEAR_READY: begin
                    ready_next = 1'b0;
                end
            endcase
        end

        status_next.frame_ready  = ready_next;
        status_next.frame_length = length_next;
        status_next.error_code   = error_next;
        status_next.overflow     = overflow_next;
        status_next.rd_hit       = rd_hit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HUNT1;
            count_reg      <= 9'd0;
            decl_reg       <= 8'd0;
            bank_reg       <= 1'b0;
            ready_reg      <= 1'b0;
            length_reg     <= 9'd0;
            error_reg      <= ERR_NONE;
            overflow_reg   <= 1'b0;
            first_hdr_reg  <= FIRST_HEADER_RST;
            second_hdr_reg <= SECOND_HEADER_RST;
        end else begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            decl_reg     <= decl_next;
            bank_reg     <= bank_next;
            ready_reg    <= ready_next;
            length_reg   <= length_next;
            error_reg    <= error_next;
            overflow_reg <= overflow_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_FIRST_HEADER:  first_hdr_reg  <= cfg_data;
                    REG_SECOND_HEADER: second_hdr_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/header_length_frame_receiver.sv */
`default_nettype none

// Frame receiver for a byte stream of the form first header, second header,
// length L, then payload until L+3 bytes in total (L of zero still takes one
// payload byte). Each transfer on the s_ side is a received byte, a line
// error event, a read of the stored frame at s_read_index, or a clear of the
// ready flag, and gives exactly one transfer on the m_ side with the status
// after that item. One item is taken every clock cycle unless the m_ side
// stalls; results pass the s1 register and then the output register. Frames
// are stored in a single-port frame memory of two banks that swap when a
// frame completes without overflow; each item makes at most one access to
// it. The user must set header values through the cfg_ port while the block
// is idle, unchecked by the block (index 0 first header, index 1 second).
module header_length_frame_receiver (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    input  wire logic                           s_valid,
    output      logic                           s_ready,
    input  wire logic [1:0]                     s_mode,
    input  wire logic [7:0]                     s_rx_byte,
    input  wire logic                           s_noise_err,
    input  wire logic                           s_parity_err,
    input  wire logic                           s_overrun_err,
    input  wire logic                           s_framing_err,
    input  wire logic [7:0]                     s_read_index,

    output      logic                           m_valid,
    input  wire logic                           m_ready,
    output      logic                           m_frame_ready,
    output      logic [8:0]                     m_frame_length,
    output      logic [7:0]                     m_read_data,
    output      logic [2:0]                     m_error_code,
    output      logic                           m_overflow,

    input  wire logic                           cfg_valid,
    output      logic                           cfg_ready,
    input  wire logic [hlfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                     cfg_data
);

    import hlfr_pkg::*;

    logic     accept;
    logic     advance;
    mem_req_t mem_req;
    status_t  status_next;
    logic [7:0] rdata;

    logic    s1_valid_reg;
    status_t s1_status_reg;
    logic    m_valid_reg;

    assign cfg_ready = 1'b1;
    assign advance   = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !s1_valid_reg || !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;

    hlfr_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .mode        (s_mode),
        .rx_byte     (s_rx_byte),
        .noise_err   (s_noise_err),
        .parity_err  (s_parity_err),
        .overrun_err (s_overrun_err),
        .framing_err (s_framing_err),
        .read_index  (s_read_index),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mem_req     (mem_req),
        .status_next (status_next)
    );

    hlfr_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_frame_mem (
        .clk   (aclk),
        .en    (mem_req.en),
        .we    (mem_req.we),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_status_reg <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_frame_ready  <= s1_status_reg.frame_ready;
            m_frame_length <= s1_status_reg.frame_length;
            m_error_code   <= s1_status_reg.error_code;
            m_overflow     <= s1_status_reg.overflow;
            m_read_data    <= s1_status_reg.rd_hit ? rdata : 8'd0;
        end
    end

endmodule

`default_nettype wire
